@@ sv/ils_pkg.sv @@
package ils_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_READ  = 2'd1,
    S_SHIFT = 2'd2
  } state_e;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned WordW    = 32;
  localparam int unsigned IndexW   = 6;
  localparam int unsigned CountW   = 7;

endpackage

@@ sv/indexed_lifo_stack.sv @@
// Bounded stack of signed words with indexed pop and peek.
// The slave channel takes one request word: tuser carries the operation
// (push, pop at index, peek at index, clear) and tdata carries the push word
// and the depth index counted from the top. The master channel returns one
// result word per request: tuser carries the status and tdata carries the
// word read and the number of entries held after the request.
// Push, clear and any request whose index is not present are answered directly,
// and their result is registered in the cycle after the request is taken.
// Peek first reads the entry memory synchronously, then registers the word read.
// Pop at index i first reads the removed entry in the same way; then the i entries
// above it move down one slot per cycle through the single read port and single
// write port of the entry memory.
// A new request is taken only when the sequencer is idle and the result
// register is empty or being drained in the same cycle, so a stalled
// receiver holds its result and blocks further requests.
// Reset empties the stack at once; the entry memory itself is not cleared
// and holds no valid data until pushed.
module indexed_lifo_stack #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // push_value [31:0], depth_index [37:32], zero [39:38]
  input  logic [39:0] s_axis_tdata,
  // op [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_value [31:0], entry_count [38:32], zero [39]
  output logic [39:0] m_axis_tdata,
  // status [1:0]
  output logic [1:0]  m_axis_tuser
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > ils_pkg::IndexW) ? CW : ils_pkg::IndexW;

  ils_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic            pop_q, pop_d;

  logic                                  out_valid_q, out_valid_d;
  logic signed [ils_pkg::WordW-1:0]      out_value_q, out_value_d;
  ils_pkg::status_e                      out_status_q, out_status_d;
  logic [ils_pkg::CountW-1:0]            out_count_q, out_count_d;
  logic                                  load_out;

  logic                            ram_we, ram_re;
  logic [AW-1:0]                   ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0]           ram_wdata;
  logic signed [DATA_WIDTH-1:0]    rd_data;

  ils_pkg::op_e                    op;
  logic signed [ils_pkg::WordW-1:0] push_value;
  logic [ils_pkg::IndexW-1:0]      depth_index;
  logic                            s_fire, hit, not_full, shift_start, shift_more;
  logic [AW-1:0]                   slot;
  logic [CW-1:0]                   count_dec;

  assign op          = ils_pkg::op_e'(s_axis_tuser);
  assign push_value  = s_axis_tdata[31:0];
  assign depth_index = s_axis_tdata[37:32];

  assign s_axis_tready = (state_q == ils_pkg::S_IDLE) && (!out_valid_q || m_axis_tready);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign hit         = CMPW'(depth_index) < CMPW'(count_q);
  assign not_full    = count_q < CW'(DEPTH);
  assign slot        = AW'(count_q - CW'(1) - CW'(depth_index));
  assign count_dec   = count_q - CW'(1);
  assign shift_start = pop_q && (CW'(ptr_q) < count_dec);
  assign shift_more  = (CW'(ptr_q) + CW'(1)) < count_q;

  ils_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ils_pkg::S_IDLE: begin
        if (s_fire && (op == ils_pkg::OP_POP || op == ils_pkg::OP_PEEK) && hit) begin
          state_d = ils_pkg::S_READ;
        end
      end
      ils_pkg::S_READ: begin
        state_d = shift_start ? ils_pkg::S_SHIFT : ils_pkg::S_IDLE;
      end
      ils_pkg::S_SHIFT: begin
        if (!shift_more) begin
          state_d = ils_pkg::S_IDLE;
        end
      end
      default: state_d = ils_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = ptr_q;
    ram_wdata    = rd_data;
    ram_re       = 1'b0;
    ram_raddr    = slot;
    count_d      = count_q;
    ptr_d        = ptr_q;
    pop_d        = pop_q;
    load_out     = 1'b0;
    out_value_d  = '0;
    out_status_d = ils_pkg::ST_OK;
    unique case (state_q)
      ils_pkg::S_IDLE: begin
        if (s_fire) begin
          unique case (op)
            ils_pkg::OP_PUSH: begin
              load_out = 1'b1;
              if (not_full) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(count_q);
                ram_wdata = DATA_WIDTH'(push_value);
                count_d   = count_q + CW'(1);
              end else begin
                out_status_d = ils_pkg::ST_FULL;
              end
            end
            ils_pkg::OP_CLEAR: begin
              load_out = 1'b1;
              count_d  = '0;
            end
            ils_pkg::OP_POP, ils_pkg::OP_PEEK: begin
              if (hit) begin
                ram_re = 1'b1;
                ptr_d  = slot;
                pop_d  = (op == ils_pkg::OP_POP);
              end else begin
                load_out     = 1'b1;
                out_status_d = ils_pkg::ST_MISSING;
              end
            end
            default: ;
          endcase
        end
      end
      ils_pkg::S_READ: begin
        load_out    = 1'b1;
        out_value_d = ils_pkg::WordW'(rd_data);
        if (pop_q) begin
          count_d = count_dec;
        end
        if (shift_start) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + AW'(1);
        end
      end
      ils_pkg::S_SHIFT: begin
        ram_we = 1'b1;
        if (shift_more) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + AW'(2);
          ptr_d     = ptr_q + AW'(1);
        end
      end
      default: ;
    endcase
    out_count_d = ils_pkg::CountW'(count_d);
    out_valid_d = load_out || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ils_pkg::S_IDLE;
      count_q     <= '0;
      pop_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pop_q       <= pop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (load_out) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_count_q  <= out_count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_value_q};
  assign m_axis_tuser  = out_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ils_pkg::S_READ |-> !out_valid_q)
    else $error("result register busy when a read result arrives");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && op == ils_pkg::OP_PUSH && not_full) |=> count_q == $past(count_q) + CW'(1))
    else $error("push did not grow the stack by one");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ils_pkg::S_SHIFT |-> CW'(ptr_q) < count_q)
    else $error("shift pointer beyond the stack top");

  a_shift_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ils_pkg::S_SHIFT |=> count_q == $past(count_q))
    else $error("entry count changed while closing the gap");

endmodule

@@ sv/ils_ram.sv @@
module ils_ram #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [DATA_WIDTH-1:0]      wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [DATA_WIDTH-1:0]      rdata_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ tb/tb_indexed_lifo_stack.sv @@
module tb_indexed_lifo_stack;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned RandomWords = 1000;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned TailCycles = 100;

  typedef struct packed {
    logic [ils_pkg::WordW-1:0]  value;
    ils_pkg::status_e           status;
    logic [ils_pkg::CountW-1:0] count;
  } reply_t;

  class lifo_scoreboard;
    logic [ils_pkg::WordW-1:0] slots [StackDepth];
    int unsigned depth_now;
    int unsigned deepest;
    reply_t pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned full_hits;
    int unsigned absent_hits;
    int unsigned op_hits [4];

    function void report(string msg);
      errors++;
      if (errors <= 10) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endfunction

    function void note_request(ils_pkg::op_e op, logic [ils_pkg::WordW-1:0] value,
                               logic [ils_pkg::IndexW-1:0] idx);
      reply_t r;
      int unsigned slot;
      r.value = '0;
      r.status = ils_pkg::ST_OK;
      op_hits[int'(op)]++;
      case (op)
        ils_pkg::OP_PUSH: begin
          if (depth_now >= StackDepth) begin
            r.status = ils_pkg::ST_FULL;
            full_hits++;
          end else begin
            slots[depth_now] = value;
            depth_now++;
          end
        end
        ils_pkg::OP_POP, ils_pkg::OP_PEEK: begin
          if (idx >= depth_now) begin
            r.status = ils_pkg::ST_MISSING;
            absent_hits++;
          end else begin
            slot = depth_now - 1 - idx;
            r.value = slots[slot];
            if (op == ils_pkg::OP_POP) begin
              for (int unsigned k = slot; k + 1 < depth_now; k++) begin
                slots[k] = slots[k + 1];
              end
              depth_now--;
            end
          end
        end
        default: begin
          depth_now = 0;
        end
      endcase
      if (depth_now > deepest) begin
        deepest = depth_now;
      end
      r.count = depth_now[ils_pkg::CountW-1:0];
      pending.push_back(r);
    endfunction

    function void check_reply(logic [ils_pkg::WordW-1:0] value, logic [1:0] status,
                              logic [ils_pkg::CountW-1:0] count);
      reply_t r;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing expected: value %h status %0d count %0d",
                         value, status, count));
      end else begin
        r = pending.pop_front();
        checked++;
        if (value !== r.value) begin
          report($sformatf("read_value expected %h got %h", r.value, value));
        end
        if (status !== r.status) begin
          report($sformatf("status expected %0d got %0d", r.status, status));
        end
        if (count !== r.count) begin
          report($sformatf("entry_count expected %0d got %0d", r.count, count));
        end
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [ils_pkg::InDataW-1:0]  s_axis_tdata;
  logic [1:0]                   s_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [ils_pkg::OutDataW-1:0] m_axis_tdata;
  logic [1:0]                   m_axis_tuser;

  lifo_scoreboard sb;
  bit             no_gaps;
  int unsigned    idle_cycles;
  int unsigned    sent;

  indexed_lifo_stack #(
    .DEPTH     (StackDepth),
    .DATA_WIDTH(ils_pkg::WordW)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 7);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_reply(m_axis_tdata[ils_pkg::WordW-1:0], m_axis_tuser,
                       m_axis_tdata[ils_pkg::WordW+ils_pkg::CountW-1:ils_pkg::WordW]);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_request(ils_pkg::op_e'(s_axis_tuser), s_axis_tdata[ils_pkg::WordW-1:0],
                        s_axis_tdata[ils_pkg::WordW+ils_pkg::IndexW-1:ils_pkg::WordW]);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d cycles without a handshake", idle_cycles);
      $display("tb_indexed_lifo_stack: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk_i);
    end
  end

  task automatic send_request(ils_pkg::op_e op, logic [ils_pkg::WordW-1:0] value,
                              logic [ils_pkg::IndexW-1:0] idx);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, idx, value};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (sb.pending.size() != 0);
  endtask

  function automatic logic [ils_pkg::IndexW-1:0] pick_index();
    if (sb.depth_now > 0 && $urandom_range(0, 99) < 85) begin
      return ils_pkg::IndexW'($urandom_range(0, sb.depth_now - 1));
    end
    return ils_pkg::IndexW'($urandom_range(0, 63));
  endfunction

  task automatic random_request();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_request(ils_pkg::OP_PUSH, $urandom(), ils_pkg::IndexW'($urandom_range(0, 63)));
    end else if (pick < 70) begin
      send_request(ils_pkg::OP_POP, $urandom(), pick_index());
    end else if (pick < 95) begin
      send_request(ils_pkg::OP_PEEK, $urandom(), pick_index());
    end else begin
      send_request(ils_pkg::OP_CLEAR, $urandom(), ils_pkg::IndexW'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    int unsigned kind;
    int unsigned run_len;
    bit drained_mid;
    sb = new();
    no_gaps = 1'b0;
    sent = 0;
    drained_mid = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ils_pkg::OP_PUSH;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_request(ils_pkg::OP_POP, 32'h0, 6'd0);
    send_request(ils_pkg::OP_PEEK, 32'h0, 6'd63);
    send_request(ils_pkg::OP_CLEAR, 32'hffff_ffff, 6'd63);
    send_request(ils_pkg::OP_PUSH, 32'h7fff_ffff, 6'd0);
    send_request(ils_pkg::OP_PUSH, 32'h8000_0000, 6'd63);
    send_request(ils_pkg::OP_PUSH, 32'h0000_0000, 6'd0);
    send_request(ils_pkg::OP_PUSH, 32'hffff_ffff, 6'd0);
    send_request(ils_pkg::OP_PUSH, 32'haaaa_aaaa, 6'd0);
    send_request(ils_pkg::OP_PUSH, 32'h5555_5555, 6'd0);
    send_request(ils_pkg::OP_PEEK, 32'h0, 6'd0);
    send_request(ils_pkg::OP_PEEK, 32'h0, 6'd5);
    send_request(ils_pkg::OP_PEEK, 32'h0, 6'd6);
    send_request(ils_pkg::OP_POP, 32'h0, 6'd2);
    send_request(ils_pkg::OP_POP, 32'h0, 6'd4);
    send_request(ils_pkg::OP_POP, 32'h0, 6'd0);
    send_request(ils_pkg::OP_PEEK, 32'h0, 6'd63);
    send_request(ils_pkg::OP_POP, 32'h0, 6'd63);
    send_request(ils_pkg::OP_CLEAR, 32'h0, 6'd0);
    send_request(ils_pkg::OP_PEEK, 32'h0, 6'd0);
    send_request(ils_pkg::OP_PUSH, 32'h1234_5678, 6'd0);
    send_request(ils_pkg::OP_POP, 32'h0, 6'd0);
    send_request(ils_pkg::OP_POP, 32'h0, 6'd0);
    wait_until_drained();

    while (sent < RandomWords) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        while (sb.depth_now < StackDepth) begin
          send_request(ils_pkg::OP_PUSH, $urandom(), ils_pkg::IndexW'($urandom_range(0, 63)));
        end
        repeat ($urandom_range(1, 3)) begin
          send_request(ils_pkg::OP_PUSH, $urandom(), ils_pkg::IndexW'($urandom_range(0, 63)));
        end
        send_request(ils_pkg::OP_PEEK, $urandom(), 6'd63);
        send_request(ils_pkg::OP_POP, $urandom(), 6'd63);
        send_request(ils_pkg::OP_POP, $urandom(), pick_index());
      end else if (kind < 12) begin
        send_request(ils_pkg::OP_CLEAR, $urandom(), ils_pkg::IndexW'($urandom_range(0, 63)));
      end else begin
        run_len = $urandom_range(1, 20);
        repeat (run_len) random_request();
      end
      if (!drained_mid && sent >= RandomWords / 2) begin
        drained_mid = 1'b1;
        wait_until_drained();
      end
    end

    no_gaps = 1'b0;
    wait_until_drained();
    repeat (TailCycles) @(negedge clk_i);
    while (sb.pending.size() != 0) begin
      void'(sb.pending.pop_front());
      sb.report("expected result never arrived");
    end

    $display("covered %0d requests: %0d push, %0d pop, %0d peek, %0d clear",
             sent, sb.op_hits[ils_pkg::OP_PUSH], sb.op_hits[ils_pkg::OP_POP],
             sb.op_hits[ils_pkg::OP_PEEK], sb.op_hits[ils_pkg::OP_CLEAR]);
    $display("%0d results checked, pushes refused when full: %0d, absent indexes: %0d",
             sb.checked, sb.full_hits, sb.absent_hits);
    $display("deepest stack: %0d, errors: %0d", sb.deepest, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_indexed_lifo_stack: PASS");
    end else begin
      $display("tb_indexed_lifo_stack: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ils_pkg.sv
sv/ils_ram.sv
sv/indexed_lifo_stack.sv
tb/tb_indexed_lifo_stack.sv
